/* hdl/lpi_pkg.sv */
// ----------------------------------------------------------------------------
// lpi_pkg
// Types, constants and per-channel prediction functions for the inverse
// lossless predictor transform.
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int PIX_W       = 32;
    localparam int MODE_W      = 4;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 15;
    localparam int ROW_W       = 14;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int MAX_HEIGHT  = 16384;

    localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hff00_0000;
    localparam logic [PIX_W-1:0] AVG_MASK     = 32'hfefe_fefe;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_BLACK      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_L          = 4'd1;
    localparam logic [MODE_W-1:0] MODE_T          = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TR         = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TL         = 4'd4;
    localparam logic [MODE_W-1:0] MODE_AVG_LTR_T  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_AVG_L_TL   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_AVG_L_T    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_AVG_TL_T   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_AVG_T_TR   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_AVG_QUAD   = 4'd10;
    localparam logic [MODE_W-1:0] MODE_SELECT     = 4'd11;
    localparam logic [MODE_W-1:0] MODE_CLAMP_FULL = 4'd12;
    localparam logic [MODE_W-1:0] MODE_CLAMP_HALF = 4'd13;
    localparam logic [MODE_W-1:0] MODE_SPARE_0    = 4'd14;
    localparam logic [MODE_W-1:0] MODE_SPARE_1    = 4'd15;

    typedef struct packed {
        logic [PIX_W-1:0]  residual_pixel;
        logic [MODE_W-1:0] mode;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_pixel;
    } out_item_t;

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (((a ^ b) & AVG_MASK) >> 1) + (a & b);
    endfunction

    function automatic logic [7:0] clamp255(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 10'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_full(input logic [PIX_W-1:0] l,
                                                    input logic [PIX_W-1:0] t,
                                                    input logic [PIX_W-1:0] tl);
        logic [PIX_W-1:0]   r;
        logic signed [9:0]  v;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            v = $signed({2'b00, l[8*c +: 8]}) + $signed({2'b00, t[8*c +: 8]})
              - $signed({2'b00, tl[8*c +: 8]});
            r[8*c +: 8] = clamp255(v);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_half(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0]   r;
        logic signed [9:0]  d;
        logic signed [9:0]  half;
        logic signed [9:0]  v;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            d    = $signed({2'b00, a[8*c +: 8]}) - $signed({2'b00, b[8*c +: 8]});
            half = (d + $signed({9'd0, d[9]})) >>> 1;
            v    = $signed({2'b00, a[8*c +: 8]}) + half;
            r[8*c +: 8] = clamp255(v);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] select_pred(input logic [PIX_W-1:0] l,
                                                     input logic [PIX_W-1:0] t,
                                                     input logic [PIX_W-1:0] tl);
        logic [9:0] dist_t;
        logic [9:0] dist_l;
        logic [7:0] dt;
        logic [7:0] dl;
        dist_t = '0;
        dist_l = '0;
        for (int c = 0; c < 4; c++)
        begin
            dt = (t[8*c +: 8] >= tl[8*c +: 8]) ? t[8*c +: 8] - tl[8*c +: 8]
                                               : tl[8*c +: 8] - t[8*c +: 8];
            dl = (l[8*c +: 8] >= tl[8*c +: 8]) ? l[8*c +: 8] - tl[8*c +: 8]
                                               : tl[8*c +: 8] - l[8*c +: 8];
            dist_t = dist_t + {2'b00, dt};
            dist_l = dist_l + {2'b00, dl};
        end
        return (dist_t < dist_l) ? l : t;
    endfunction

    function automatic logic [PIX_W-1:0] predict(input logic [MODE_W-1:0] m,
                                                 input logic [PIX_W-1:0]  l,
                                                 input logic [PIX_W-1:0]  t,
                                                 input logic [PIX_W-1:0]  tr,
                                                 input logic [PIX_W-1:0]  tl);
        logic [PIX_W-1:0] p;
        case (m)
            MODE_BLACK:      p = OPAQUE_BLACK;
            MODE_L:          p = l;
            MODE_T:          p = t;
            MODE_TR:         p = tr;
            MODE_TL:         p = tl;
            MODE_AVG_LTR_T:  p = avg2(avg2(l, tr), t);
            MODE_AVG_L_TL:   p = avg2(l, tl);
            MODE_AVG_L_T:    p = avg2(l, t);
            MODE_AVG_TL_T:   p = avg2(tl, t);
            MODE_AVG_T_TR:   p = avg2(t, tr);
            MODE_AVG_QUAD:   p = avg2(avg2(l, tl), avg2(t, tr));
            MODE_SELECT:     p = select_pred(l, t, tl);
            MODE_CLAMP_FULL: p = clamp_full(l, t, tl);
            default:         p = clamp_half(avg2(l, t), tl);
        endcase
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] add_pixels(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        for (int c = 0; c < 4; c++)
        begin
            r[8*c +: 8] = a[8*c +: 8] + b[8*c +: 8];
        end
        return r;
    endfunction

endpackage

/* hdl/lpi_line_buf.sv */
// ----------------------------------------------------------------------------
// lpi_line_buf
// Previous-row line buffer: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lpi_line_buf
    import lpi_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lossless_predictor_inverse.sv */
// ----------------------------------------------------------------------------
// lossless_predictor_inverse
// Rebuilds ARGB pixels from predictor residuals in raster order, keeping the
// previous row in a line buffer memory.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data  (residual_pixel, mode)
//   out       output     out_valid / out_ready out_data (pixel, last_pixel)
//   cfg       input      cfg_wr_en             cfg_index, cfg_wr_data
//
// One pixel per clock unless out stalls; each transfer on in is registered
// before it appears on out. The rate is set by the single read port of the
// line buffer, which prefetches the top-right neighbour of the next pixel at
// every transfer. Reset clears position, neighbour registers and out_valid;
// output data and the line buffer are not cleared. A stall on out holds the
// output register; in_ready drops only while it is full and not taken.
// ----------------------------------------------------------------------------
module lossless_predictor_inverse
    import lpi_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    logic [CW-1:0]       col_reg,      col_next;
    logic [ROW_W-1:0]    row_reg,      row_next;
    logic [PIX_W-1:0]    left_reg;
    logic [PIX_W-1:0]    tl_reg;
    logic [PIX_W-1:0]    row_start_reg, row_start_next;
    logic [PIX_W-1:0]    t_reg,        t_next;
    logic                fwd_reg,      fwd_next;
    logic [CW-1:0]       rd_addr_reg,  rd_addr_next;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                accept;
    logic [CW:0]         col_inc;
    logic                last_col;
    logic                last_row;
    logic [PIX_W-1:0]    rd_data;
    logic [PIX_W-1:0]    tr_cur;
    logic [PIX_W-1:0]    pred;
    logic [PIX_W-1:0]    pix;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lpi_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (pix),
        .rd_addr (rd_addr_next),
        .rd_data (rd_data)
    );

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + {{CW{1'b0}}, 1'b1};
        last_col = (CMPW'(col_inc) >= CMPW'(width_reg))
                || (col_reg == CW'(MAX_WIDTH - 1));
        last_row = ((HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= height_reg)
                || (row_reg == ROW_W'(MAX_HEIGHT - 1));

        tr_cur = last_col ? row_start_reg : (fwd_reg ? left_reg : rd_data);

        if (col_reg == '0 && row_reg == '0)
        begin
            pred = OPAQUE_BLACK;
        end
        else if (row_reg == '0)
        begin
            pred = left_reg;
        end
        else if (col_reg == '0)
        begin
            pred = t_reg;
        end
        else
        begin
            pred = predict(in_data.mode, left_reg, t_reg, tr_cur, tl_reg);
        end

        pix = add_pixels(in_data.residual_pixel, pred);

        row_start_next = (col_reg == '0) ? pix : row_start_reg;

        if (last_col)
        begin
            col_next     = '0;
            row_next     = last_row ? '0 : row_reg + ROW_W'(1);
            t_next       = row_start_next;
            rd_addr_next = CW'(1);
            fwd_next     = (col_reg == CW'(1));
        end
        else
        begin
            col_next     = col_inc[CW-1:0];
            row_next     = row_reg;
            t_next       = tr_cur;
            rd_addr_next = CW'(col_inc + (CW+1)'(1));
            fwd_next     = 1'b0;
        end

        if (!accept)
        begin
            rd_addr_next = rd_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            tl_reg        <= '0;
            row_start_reg <= '0;
            t_reg         <= '0;
            fwd_reg       <= 1'b0;
            rd_addr_reg   <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            if (accept)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                left_reg      <= pix;
                tl_reg        <= t_reg;
                row_start_reg <= row_start_next;
                t_reg         <= t_next;
                fwd_reg       <= fwd_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.pixel      <= pix;
            out_data_reg.last_pixel <= last_col && last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_W-1:0];
            endcase
        end
    end

endmodule
